FILE: sv/sha1h_pkg.sv
package sha1h_pkg;

    localparam int ROUNDS  = 80;
    localparam int ROUND_W = 7;
    localparam int WORDS   = 5;

    typedef logic [31:0] t_word;
    typedef t_word [WORDS-1:0] t_chain;

    // h0 sits in the lowest slot
    localparam t_chain INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_CH  = 32'h5A827999;
    localparam t_word K_PA0 = 32'h6ED9EBA1;
    localparam t_word K_MAJ = 32'h8F1BBCDC;
    localparam t_word K_PA1 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic               load;
        logic               step;
        logic               put_byte;
        logic [ROUND_W-1:0] round;
    } t_ctl;

    function automatic t_word sha1h_k(input logic [ROUND_W-1:0] round);
        t_word k;
        priority if (round < ROUND_W'(20)) begin
            k = K_CH;
        end else if (round < ROUND_W'(40)) begin
            k = K_PA0;
        end else if (round < ROUND_W'(60)) begin
            k = K_MAJ;
        end else begin
            k = K_PA1;
        end
        return k;
    endfunction

endpackage

FILE: sv/sha1_hasher_core.sv
// sha-1 digest engine, one message byte per input beat
// input stream: tdata[7:0] message byte, tuser = byte present, tlast = end of
// message. a beat with tuser low and tlast high ends the message as is, so an
// empty message is allowed. a beat with neither flag does nothing.
// output stream: five beats per message, h0 first. tdata[31:0] digest word,
// tdata[34:32] word index, tdata[39:35] zero, tlast on h4.
// timing: a byte that neither completes a 64-byte block nor ends the message
// leaves tready high. a byte that completes a block starts the load, then 80
// rounds on the single round unit and a chaining add run before tready returns.
// at end of message the padding bytes go in at one per cycle while no block is
// compressed (up to 64, or up to 72 when the length spills into a second block);
// full blocks are compressed likewise; the five digest beats follow back to back.
// tready is low while a block is compressed, and from message end until the
// last digest beat is taken; a stalled output simply holds the current beat.
// after reset, and after the h4 beat, the chaining words hold the sha-1
// initial values and the byte count is zero: ready for a new message.
module sha1_hasher_core
    import sha1h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [2:0] IDX_LAST = 3'd4;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [5:0]         r_fill;
    logic [5:0]         n_fill;
    logic [60:0]        r_count;
    logic [60:0]        n_count;
    logic [63:0]        r_len;
    logic [63:0]        n_len;
    logic               r_end;
    logic               n_end;
    logic               r_pad_first;
    logic               n_pad_first;
    logic               r_len_phase;
    logic               n_len_phase;
    logic [ROUND_W-1:0] r_round;
    logic [ROUND_W-1:0] n_round;
    logic [2:0]         r_idx;
    logic [2:0]         n_idx;
    t_chain             r_chain;
    t_chain             n_chain;

    t_ctl               ctl;
    t_word              w;
    t_chain             st;
    logic [7:0]         put_val;
    logic               len_sel;
    logic               in_acc;
    logic               out_acc;
    t_word              out_word;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // length bytes start at lane 56 unless 0x80 itself landed on or past it
    assign len_sel = !r_pad_first && (r_len_phase || (r_fill == FILL_LEN));

    always_comb begin
        if (r_state == ST_PAD) begin
            if (r_pad_first) begin
                put_val = PAD_BYTE;
            end else if (len_sel) begin
                put_val = r_len[63:56];
            end else begin
                put_val = '0;
            end
        end else begin
            put_val = s_axis_tdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_count     = r_count;
        n_len       = r_len;
        n_end       = r_end;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_round     = r_round;
        n_idx       = r_idx;
        n_chain     = r_chain;
        ctl         = '0;
        ctl.round   = r_round;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_end = s_axis_tlast;
                    if (s_axis_tuser) begin
                        ctl.put_byte = 1'b1;
                        n_fill       = r_fill + 6'd1;
                        n_count      = r_count + 61'd1;
                    end
                    if (s_axis_tlast) begin
                        n_len       = {n_count, 3'b000};
                        n_pad_first = 1'b1;
                        n_len_phase = 1'b0;
                    end
                    if (s_axis_tuser && (r_fill == FILL_LAST)) begin
                        ctl.load = 1'b1;
                        n_round  = '0;
                        n_state  = ST_ROUND;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.put_byte = 1'b1;
                n_fill       = r_fill + 6'd1;
                n_pad_first  = 1'b0;
                if (len_sel) begin
                    n_len       = {r_len[55:0], 8'h00};
                    n_len_phase = 1'b1;
                end
                if (r_fill == FILL_LAST) begin
                    ctl.load = 1'b1;
                    n_round  = '0;
                    n_state  = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctl.step = 1'b1;
                n_round  = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS - 1)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < WORDS; i++) begin
                    n_chain[i] = r_chain[i] + st[i];
                end
                priority if (r_end && r_len_phase) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else if (r_end) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (r_idx == IDX_LAST) begin
                        n_chain     = INIT_CHAIN;
                        n_count     = '0;
                        n_fill      = '0;
                        n_end       = 1'b0;
                        n_len_phase = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_end       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_round     <= '0;
            r_idx       <= '0;
            r_chain     <= INIT_CHAIN;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_end       <= n_end;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    sha1h_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_byte (put_val),
        .o_w    (w)
    );

    sha1h_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_chain (r_chain),
        .i_w     (w),
        .o_state (st)
    );

    always_comb begin
        unique case (r_idx)
            3'd0:    out_word = r_chain[0];
            3'd1:    out_word = r_chain[1];
            3'd2:    out_word = r_chain[2];
            3'd3:    out_word = r_chain[3];
            3'd4:    out_word = r_chain[4];
            default: out_word = '0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {5'b00000, r_idx, out_word};
    assign m_axis_tlast  = (r_idx == IDX_LAST);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output channels active together");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round < ROUND_W'(ROUNDS)))
        else $error("round counter out of range");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && $past(r_state) != ST_ROUND) |-> (r_fill == 6'd0))
        else $error("compression started on a partial block");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_idx <= IDX_LAST))
        else $error("digest word index out of range");

    a_out_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && $past(r_state) != ST_OUT) |->
        ($past(r_state) == ST_FINAL && r_len_phase && r_idx == 3'd0))
        else $error("digest output entered without final block");

endmodule

FILE: sv/sha1h_sched.sv
module sha1h_sched
    import sha1h_pkg::*;
(
    input  logic       i_clk,
    input  t_ctl       i_ctl,
    input  logic [7:0] i_byte,
    output t_word      o_w
);

    logic [511:0] r_win;
    t_word        w0;
    t_word        w2;
    t_word        w8;
    t_word        w13;
    t_word        n_w;

    // word i of the window lives at bits [511-32*i -: 32]
    assign w0  = r_win[511:480];
    assign w2  = r_win[447:416];
    assign w8  = r_win[255:224];
    assign w13 = r_win[95:64];

    always_comb begin
        n_w = w13 ^ w8 ^ w2 ^ w0;
        n_w = {n_w[30:0], n_w[31]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.put_byte) begin
            r_win <= {r_win[503:0], i_byte};
        end else if (i_ctl.step) begin
            r_win <= {r_win[479:0], n_w};
        end
    end

    assign o_w = w0;

endmodule

FILE: sv/sha1h_round.sv
module sha1h_round
    import sha1h_pkg::*;
(
    input  logic   i_clk,
    input  t_ctl   i_ctl,
    input  t_chain i_chain,
    input  t_word  i_w,
    output t_chain o_state
);

    t_chain r_st;
    t_word  a;
    t_word  b;
    t_word  c;
    t_word  d;
    t_word  e;
    t_word  f;
    t_word  n_a;

    assign a = r_st[0];
    assign b = r_st[1];
    assign c = r_st[2];
    assign d = r_st[3];
    assign e = r_st[4];

    always_comb begin
        priority if (i_ctl.round < ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
        end else if (i_ctl.round < ROUND_W'(40)) begin
            f = b ^ c ^ d;
        end else if (i_ctl.round < ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        n_a = {a[26:0], a[31:27]} + f + e + sha1h_k(i_ctl.round) + i_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_st <= i_chain;
        end else if (i_ctl.step) begin
            r_st <= {d, c, {b[1:0], b[31:2]}, a, n_a};
        end
    end

    assign o_state = r_st;

endmodule
